FILE: rtl/pcc_pkg.sv
// shared types, constants and the arctangent table of the polar/cartesian converter
// used by every module of the block; depends on nothing
package pcc_pkg;

  localparam int VEC_W = 36;          // cordic vector width, signed
  localparam int ANG_W = 34;          // angle accumulator width, signed, up to 32 fraction bits
  localparam int INV_GAIN = 10188014; // 1/cordic gain in q24
  localparam int ATAN_ENTRIES = 24;

  typedef enum logic {
    KIND_POLAR = 1'b0,
    KIND_CART  = 1'b1
  } kind_t;

  // one item in flight through the rotation pipeline
  typedef struct packed {
    kind_t                   kind;
    logic                    zero;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] ang;
    logic signed [15:0]      cx;
    logic signed [15:0]      cy;
  } work_t;

  // atan(2^-i)/(2*pi) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn32(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2F9;
      15:      v = 32'h0000517C;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A2F;
      19:      v = 32'h00000517;
      20:      v = 32'h0000028B;
      21:      v = 32'h00000145;
      22:      v = 32'h000000A2;
      23:      v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/pcc_front.sv
// front end: classifies an incoming transaction and builds the starting cordic vector
// depends on pcc_pkg
module pcc_front #(
  parameter int PHASE_BITS = 16
) (
  input  logic               kind,
  input  logic [15:0]        phase_in,
  input  logic [7:0]         radius_in,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] center_x,
  input  logic signed [15:0] center_y,
  output pcc_pkg::work_t     work
);

  localparam int AW = PHASE_BITS + 8;
  localparam int VW = pcc_pkg::VEC_W;
  localparam int NW = pcc_pkg::ANG_W;

  logic [AW-1:0]         a_raw;
  logic signed [NW-1:0]  a;
  logic signed [NW-1:0]  quarter;
  logic signed [VW-1:0]  r;
  logic signed [16:0]    dx;
  logic signed [16:0]    dy;
  logic signed [VW-1:0]  x1;
  logic signed [VW-1:0]  y1;

  assign a_raw   = AW'(phase_in) << (PHASE_BITS - 8);
  assign a       = NW'(signed'(a_raw));
  assign quarter = NW'(1) <<< (PHASE_BITS + 6);
  assign r       = VW'($unsigned(radius_in) * 32'(pcc_pkg::INV_GAIN));
  assign dx      = 17'(point_x) - 17'(center_x);
  assign dy      = 17'(point_y) - 17'(center_y);
  assign x1      = -(VW'(dy) <<< 16);
  assign y1      = VW'(dx) <<< 16;

  always_comb begin
    work.kind = pcc_pkg::kind_t'(kind);
    work.cx   = center_x;
    work.cy   = center_y;
    work.zero = 1'b0;
    if (kind == pcc_pkg::KIND_POLAR) begin
      // fold the angle into the right half plane
      if (a > quarter) begin
        work.x = '0; work.y = r; work.ang = a - quarter;
      end else if (a < -quarter) begin
        work.x = '0; work.y = -r; work.ang = a + quarter;
      end else begin
        work.x = r; work.y = '0; work.ang = a;
      end
    end else begin
      work.zero = (dx == '0) && (dy == '0);
      if (x1 < 0) begin
        if (y1 >= 0) begin
          work.x = y1; work.y = -x1; work.ang = quarter;
        end else begin
          work.x = -y1; work.y = x1; work.ang = -quarter;
        end
      end else begin
        work.x = x1; work.y = y1; work.ang = '0;
      end
    end
  end

endmodule

FILE: rtl/pcc_queue.sv
// short queue between front and back end
// depends on pcc_pkg
module pcc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pcc_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pcc_pkg::work_t head
);

  pcc_pkg::work_t mem [4];
  logic [1:0]     wr_ptr;
  logic [1:0]     rd_ptr;
  logic [2:0]     count;

  assign full  = count == 3'd4;
  assign empty = count == 3'd0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/pcc_stage.sv
// one cordic micro-rotation, shared by both conversion kinds
// depends on pcc_pkg
module pcc_stage #(
  parameter int STEP       = 0,
  parameter int PHASE_BITS = 16
) (
  input  pcc_pkg::work_t d,
  output pcc_pkg::work_t q
);

  localparam int NW = pcc_pkg::ANG_W;
  localparam logic [31:0] ATAN = pcc_pkg::atan_turn32(STEP) >> (24 - PHASE_BITS);

  logic signed [pcc_pkg::VEC_W-1:0] xs;
  logic signed [pcc_pkg::VEC_W-1:0] ys;
  logic                             dir;
  logic signed [NW-1:0]             step;

  assign xs   = d.x >>> STEP;
  assign ys   = d.y >>> STEP;
  assign step = NW'(ATAN);
  // rotation mode drives the angle to zero, vectoring mode drives y to zero
  assign dir  = (d.kind == pcc_pkg::KIND_POLAR) ? (d.ang >= 0) : (d.y < 0);

  always_comb begin
    q = d;
    if (dir) begin
      q.x = d.x - ys; q.y = d.y + xs; q.ang = d.ang - step;
    end else begin
      q.x = d.x + ys; q.y = d.y - xs; q.ang = d.ang + step;
    end
  end

endmodule

FILE: rtl/pcc_back.sv
// back end: elastic cordic pipeline, rounding, saturation and the output register
// depends on pcc_pkg and pcc_stage
module pcc_back #(
  parameter int ITERATIONS = 16,
  parameter int PHASE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  pcc_pkg::work_t in_data,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_x,
  output logic [15:0]    out_y,
  output logic [15:0]    out_phase,
  output logic [7:0]     out_radius,
  output logic           clipped
);

  localparam int AW = PHASE_BITS + 8;
  localparam int VW = pcc_pkg::VEC_W;

  pcc_pkg::work_t st   [ITERATIONS];
  pcc_pkg::work_t nx   [ITERATIONS];
  logic [ITERATIONS-1:0] sv;
  logic [ITERATIONS-1:0] en;

  // finishing stage registers
  logic               f_valid;
  logic               f_en;
  pcc_pkg::kind_t     f_kind;
  logic               f_zero;
  logic signed [17:0] f_rx;
  logic signed [17:0] f_ry;
  logic signed [15:0] f_cx;
  logic signed [15:0] f_cy;
  logic [58:0]        f_prod;
  logic [15:0]        f_phase;
  logic               o_en;

  pcc_pkg::work_t     last;
  logic [VW-2:0]      xc;
  logic [AW-1:0]      w;
  logic [15:0]        ph;
  logic signed [17:0] rnd_x;
  logic signed [17:0] rnd_y;

  assign o_en     = !out_valid || out_ready;
  assign f_en     = !f_valid || o_en;
  assign in_ready = en[0];

  genvar k;
  generate
    for (k = 0; k < ITERATIONS; k++) begin : g_stage
      if (k == ITERATIONS - 1) begin : g_tail
        assign en[k] = !sv[k] || f_en;
      end else begin : g_mid
        assign en[k] = !sv[k] || en[k+1];
      end
      if (k == 0) begin : g_first
        pcc_stage #(.STEP(k), .PHASE_BITS(PHASE_BITS)) u_stage (.d(in_data), .q(nx[k]));
        always_ff @(posedge clk) begin
          if (rst) begin
            sv[k] <= 1'b0;
          end else if (en[k]) begin
            sv[k] <= in_valid;
          end
        end
      end else begin : g_next
        pcc_stage #(.STEP(k), .PHASE_BITS(PHASE_BITS)) u_stage (.d(st[k-1]), .q(nx[k]));
        always_ff @(posedge clk) begin
          if (rst) begin
            sv[k] <= 1'b0;
          end else if (en[k]) begin
            sv[k] <= sv[k-1];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en[k]) begin
          st[k] <= nx[k];
        end
      end
    end
  endgenerate

  assign last = st[ITERATIONS-1];
  assign xc   = last.x < 0 ? '0 : last.x[VW-2:0];
  assign w    = last.ang[AW-1:0];

  // round half away from zero of the q24 vector
  assign rnd_x = last.x >= 0 ? 18'((last.x + (VW'(1) <<< 23)) >>> 24)
                             : -18'((-last.x + (VW'(1) <<< 23)) >>> 24);
  assign rnd_y = last.y >= 0 ? 18'((last.y + (VW'(1) <<< 23)) >>> 24)
                             : -18'((-last.y + (VW'(1) <<< 23)) >>> 24);

  generate
    if (PHASE_BITS > 8) begin : g_phase_rnd
      logic [AW:0] wsum;
      assign wsum = {1'b0, w} + ((AW+1)'(1) << (PHASE_BITS - 9));
      assign ph   = wsum[AW-1:PHASE_BITS-8];
    end else begin : g_phase_raw
      assign ph = w[15:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_en) begin
      f_valid <= sv[ITERATIONS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      f_kind  <= last.kind;
      f_zero  <= last.zero;
      f_rx    <= rnd_y;
      f_ry    <= rnd_x;
      f_cx    <= last.cx;
      f_cy    <= last.cy;
      f_prod  <= 59'(xc) * 59'(pcc_pkg::INV_GAIN);
      f_phase <= ph;
    end
  end

  // final add, saturation and magnitude rounding
  logic signed [18:0] sx;
  logic signed [18:0] sy;
  logic [18:0]        mag;
  logic [15:0]        ox_next;
  logic [15:0]        oy_next;
  logic [15:0]        oph_next;
  logic [7:0]         orad_next;
  logic               oclip_next;

  assign sx  = 19'(f_cx) + 19'(f_rx);
  assign sy  = 19'(f_cy) - 19'(f_ry);
  assign mag = 19'((f_prod + (59'(1) << 39)) >> 40);

  always_comb begin
    ox_next    = '0;
    oy_next    = '0;
    oph_next   = '0;
    orad_next  = '0;
    oclip_next = 1'b0;
    if (f_kind == pcc_pkg::KIND_POLAR) begin
      if (sx > 19'sd32767) begin
        ox_next = 16'h7FFF; oclip_next = 1'b1;
      end else if (sx < -19'sd32768) begin
        ox_next = 16'h8000; oclip_next = 1'b1;
      end else begin
        ox_next = sx[15:0];
      end
      if (sy > 19'sd32767) begin
        oy_next = 16'h7FFF; oclip_next = 1'b1;
      end else if (sy < -19'sd32768) begin
        oy_next = 16'h8000; oclip_next = 1'b1;
      end else begin
        oy_next = sy[15:0];
      end
    end else if (!f_zero) begin
      oph_next = f_phase;
      if (mag > 19'd255) begin
        orad_next = 8'hFF; oclip_next = 1'b1;
      end else begin
        orad_next = mag[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_en) begin
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      out_x      <= ox_next;
      out_y      <= oy_next;
      out_phase  <= oph_next;
      out_radius <= orad_next;
      clipped    <= oclip_next;
    end
  end

endmodule

FILE: rtl/polar_cartesian_converter.sv
// top level of the polar/cartesian converter: front end, queue and cordic back end
// depends on pcc_pkg, pcc_front, pcc_queue and pcc_back
//
// usage
//   input channel s_axis: one transaction per conversion; tuser is the kind
//     (0 polar to cartesian, 1 cartesian to polar), tdata the operands
//   output channel m_axis: exactly one result transaction per input, in order
//   throughput: one transaction per cycle while m_axis_tready is high; each
//     item passes one register per cordic micro-rotation, so the unrolled
//     rotation pipeline sets the rate
//   path to m_axis_tvalid, queue empty: queue entry written at the accepting
//     edge, then ITERATIONS rotation stages, rounding stage, output register
//   stall: a full pipeline stage holds while the one after it holds, so a
//     receiver stall backs up the pipeline and then the four entry queue;
//     s_axis_tready drops only once the queue is full
//   reset: rst is synchronous and active high; it empties the queue and the
//     pipeline, no configuration exists
//   phase 0 points up and grows clockwise on screen (y grows downward)
module polar_cartesian_converter #(
  parameter int ITERATIONS = 16,
  parameter int PHASE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // phase_in[15:0], radius_in[23:16], point_x[39:24], point_y[55:40],
  // center_x[71:56], center_y[87:72]
  input  logic [87:0] s_axis_tdata,
  // kind[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_x[15:0], out_y[31:16], out_phase[47:32], out_radius[55:48],
  // clipped[56], zero fill above
  output logic [63:0] m_axis_tdata
);

  pcc_pkg::work_t front_work;
  pcc_pkg::work_t q_head;
  logic           q_full;
  logic           q_empty;
  logic           back_ready;
  logic [15:0]    out_x;
  logic [15:0]    out_y;
  logic [15:0]    out_phase;
  logic [7:0]     out_radius;
  logic           clipped;

  assign s_axis_tready = !q_full;

  // classify and build the starting vector straight from the input transaction
  pcc_front #(.PHASE_BITS(PHASE_BITS)) u_front (
    .kind      (s_axis_tuser),
    .phase_in  (s_axis_tdata[15:0]),
    .radius_in (s_axis_tdata[23:16]),
    .point_x   (s_axis_tdata[39:24]),
    .point_y   (s_axis_tdata[55:40]),
    .center_x  (s_axis_tdata[71:56]),
    .center_y  (s_axis_tdata[87:72]),
    .work      (front_work)
  );

  // decouples acceptance from back-pressure inside the pipeline
  pcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid && !q_full),
    .push_data (front_work),
    .full      (q_full),
    .pop       (back_ready && !q_empty),
    .empty     (q_empty),
    .head      (q_head)
  );

  pcc_back #(.ITERATIONS(ITERATIONS), .PHASE_BITS(PHASE_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (!q_empty),
    .in_data    (q_head),
    .in_ready   (back_ready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_phase  (out_phase),
    .out_radius (out_radius),
    .clipped    (clipped)
  );

  assign m_axis_tdata = {7'd0, clipped, out_radius, out_phase, out_y, out_x};

endmodule
